@@ rtl/running_mean_variance_field_macros.svh @@
// assertion helpers shared by the block
`ifndef RUNNING_MEAN_VARIANCE_FIELD_MACROS_SVH
`define RUNNING_MEAN_VARIANCE_FIELD_MACROS_SVH
`define RMVF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("label failed");
`define RMVF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("label failed");
`endif

@@ rtl/rmvf_pkg.sv @@
package rmvf_pkg;
   localparam int unsigned DEPTH = 1024;
   localparam int unsigned IDX_W = 10;
   localparam int unsigned FRM_W = 20;
   localparam int unsigned M2_W = 48;
   localparam logic [FRM_W-1:0] FRAMES_MAX = '1;
   localparam logic [M2_W-1:0] M2_MAX = '1;

   typedef struct packed {
      logic signed [31:0] sample;
      logic [IDX_W-1:0] element_index;
      logic last_in_frame;
   } req_type;

   typedef struct packed {
      logic signed [31:0] mean_out;
      logic [M2_W-1:0] variance_out;
      logic variance_valid;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic signed [31:0] sample;
      logic [IDX_W-1:0] idx;
      logic in_field;
      logic [FRM_W:0] n;
   } job_type;
endpackage

@@ rtl/running_mean_variance_field.sv @@
// path from req transfer to rsp transfer runs through two pipelined dividers
// throughput: one item per cycle while rsp_ready stays high, no revisit waits and no clearing pass runs
// a revisit of an element whose last update is still in flight waits until that update is stored
// reset: synchronous, clears frame counter and queues, then a pass over all 1024 elements clears the stores
// req_ready drops during that pass once the input queue holds two items
module running_mean_variance_field #(
   parameter int unsigned ROWS = 32,
   parameter int unsigned COLS = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  rmvf_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rmvf_pkg::rsp_type rsp_data
);
   import rmvf_pkg::*;

   logic jv, jr;
   job_type jd;

   rmvf_front #(.CELLS(ROWS * COLS)) u_front (
      .clock(clock), .reset(reset), .in_valid(req_valid), .in_ready(req_ready),
      .in_data(req_data), .job_valid(jv), .job_ready(jr), .job_data(jd));

   rmvf_back u_back (
      .clock(clock), .reset(reset), .job_valid(jv), .job_ready(jr), .job_data(jd),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_data(rsp_data));
endmodule

@@ rtl/rmvf_front.sv @@
module rmvf_front #(
   parameter int unsigned CELLS = 1024
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  rmvf_pkg::req_type in_data,
   output logic job_valid,
   input  logic job_ready,
   output rmvf_pkg::job_type job_data
);
   import rmvf_pkg::*;

   logic [FRM_W-1:0] frames_ff, frames_in;
   logic [1:0] cnt_ff, cnt_in;
   job_type q_ff [2];
   logic rd_ff, wr_ff;
   logic push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign push = in_valid && in_ready;
   assign job_valid = (cnt_ff != 2'd0);
   assign pop = job_valid && job_ready;
   assign job_data = q_ff[rd_ff];

   // frame counter advances after last element, saturating
   always_comb begin
      frames_in = frames_ff;
      if (push && in_data.last_in_frame && frames_ff != FRAMES_MAX)
         frames_in = frames_ff + 1'b1;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= '0;
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         frames_ff <= frames_in;
         cnt_ff <= cnt_in;
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
      end
   end

   // queue payload
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff].sample <= in_data.sample;
         q_ff[wr_ff].idx <= in_data.element_index;
         q_ff[wr_ff].in_field <= (32'(in_data.element_index) < CELLS);
         q_ff[wr_ff].n <= {1'b0, frames_ff} + 1'b1;
      end
   end
endmodule

@@ rtl/rmvf_div.sv @@
// pipelined restoring divider, one quotient bit per stage
module rmvf_div #(
   parameter int unsigned NW = 48,
   parameter int unsigned DW = 21,
   parameter int unsigned TW = 1
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic [TW-1:0] tag_i,
   output logic [NW-1:0] quo,
   output logic [TW-1:0] tag_o
);
   for (genvar s = 0; s < NW; s++) begin : g_st
      logic [NW-1:0] q_ff;
      logic [DW-1:0] r_ff;
      logic [DW-1:0] d_ff;
      logic [TW-1:0] t_ff;
      logic [NW-1:0] qi;
      logic [DW-1:0] ri, di;
      logic [TW-1:0] ti;
      logic [DW:0] tr;
      logic ge;

      // stage inputs come from the ports or the previous stage
      if (s == 0) begin : g_in
         assign qi = num;
         assign ri = '0;
         assign di = den;
         assign ti = tag_i;
      end else begin : g_mid
         assign qi = g_st[s-1].q_ff;
         assign ri = g_st[s-1].r_ff;
         assign di = g_st[s-1].d_ff;
         assign ti = g_st[s-1].t_ff;
      end

      assign tr = {ri, qi[NW-1]};
      assign ge = tr >= {1'b0, di};

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff <= ge ? DW'(tr - {1'b0, di}) : DW'(tr);
            q_ff <= {qi[NW-2:0], ge};
            d_ff <= di;
         end
      end

      // tag carries the valid bit, so it is cleared at reset
      always_ff @(posedge clock) begin
         if (reset) begin
            t_ff <= '0;
         end else if (en) begin
            t_ff <= ti;
         end
      end
   end

   assign quo = g_st[NW-1].q_ff;
   assign tag_o = g_st[NW-1].t_ff;
endmodule

@@ rtl/rmvf_back.sv @@
module rmvf_back (
   input  logic clock,
   input  logic reset,
   input  logic job_valid,
   output logic job_ready,
   input  rmvf_pkg::job_type job_data,
   output logic out_valid,
   input  logic out_ready,
   output rmvf_pkg::rsp_type out_data
);
   import rmvf_pkg::*;
`include "running_mean_variance_field_macros.svh"

   localparam int unsigned DLY1 = 33;
   localparam int unsigned DLY2 = 48;
   localparam int unsigned LAT = 1 + DLY1 + 2 + DLY2 + 1;
   localparam int unsigned HZ = 1 + DLY1 + 2;
   localparam int unsigned FIFO_D = 128;
   localparam int unsigned FA = 7;

   // pipe runs freely; input is held off while the output fifo could not absorb the flight
   logic en;
   logic [FA:0] mcnt_ff;
   logic ov_ff;
   logic [7:0] fly_ff;
   logic fire;
   logic hit;
   logic clr_act_ff;
   logic [IDX_W-1:0] clr_ff;
   logic [HZ-1:0] hz_v_ff;
   logic [IDX_W-1:0] hz_idx_ff [HZ];

   assign job_ready = !clr_act_ff && !(hit && job_data.in_field) &&
                      (32'(mcnt_ff) + 32'(ov_ff) + 32'(fly_ff) < FIFO_D);
   assign fire = job_valid && job_ready;
   assign en = 1'b1;

   // element updates not yet written back to the stores
   always_comb begin
      hit = 1'b0;
      for (int i = 0; i < HZ; i++) begin
         if (hz_v_ff[i] && hz_idx_ff[i] == job_data.idx) hit = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hz_v_ff <= '0;
      end else begin
         hz_v_ff <= {hz_v_ff[HZ-2:0], fire && job_data.in_field};
      end
   end

   always_ff @(posedge clock) begin
      hz_idx_ff[0] <= job_data.idx;
      for (int i = 1; i < HZ; i++) hz_idx_ff[i] <= hz_idx_ff[i-1];
   end

   // clearing pass over the stores after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_act_ff <= 1'b1;
         clr_ff <= '0;
      end else if (clr_act_ff) begin
         clr_ff <= clr_ff + 1'b1;
         if (clr_ff == IDX_W'(DEPTH - 1)) clr_act_ff <= 1'b0;
      end
   end

   // per-element stores
   logic [31:0] mean_mem [DEPTH];
   logic [M2_W-1:0] m2_mem [DEPTH];

   // stage 0: read stores
   logic v0_ff;
   job_type j0_ff;
   logic [31:0] mr_ff;
   logic [M2_W-1:0] m2r_ff;
   always_ff @(posedge clock) begin
      mr_ff <= mean_mem[job_data.idx];
      m2r_ff <= m2_mem[job_data.idx];
      j0_ff <= job_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= fire;
      end
   end

   // d and abs for mean divide
   logic signed [32:0] d0;
   logic signed [31:0] mean0;
   assign mean0 = $signed(mr_ff);
   assign d0 = 33'(j0_ff.sample) - 33'(mean0);

   typedef struct packed {
      logic neg;
      logic signed [31:0] mean;
      logic [M2_W-1:0] m2;
      job_type j;
      logic v;
   } t1_type;
   t1_type t1_i, t1_o;
   logic [32:0] dmag, dq;
   assign dmag = d0[32] ? 33'(-d0) : 33'(d0);
   assign t1_i = '{neg: d0[32], mean: mean0, m2: m2r_ff, j: j0_ff, v: v0_ff};

   rmvf_div #(.NW(33), .DW(FRM_W+1), .TW($bits(t1_type))) u_div1 (
      .clock(clock), .reset(reset), .en(en), .num(dmag), .den(t1_i.j.n),
      .tag_i(t1_i), .quo(dq), .tag_o(t1_o));

   // stage a: mean_new and e
   logic signed [31:0] mnew_ff;
   logic [32:0] ad_ff, ae_ff;
   t1_type ta_ff;
   logic signed [33:0] dd;
   logic signed [32:0] mn_w, e_w;
   assign dd = t1_o.neg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});
   assign mn_w = 33'(t1_o.mean) + 33'(dd);
   assign e_w = 33'(t1_o.j.sample) - mn_w;
   always_ff @(posedge clock) begin
      mnew_ff <= mn_w[31:0];
      ad_ff <= t1_o.neg ? 33'(-(33'(t1_o.j.sample) - 33'(t1_o.mean)))
                        : 33'(33'(t1_o.j.sample) - 33'(t1_o.mean));
      ae_ff <= e_w[32] ? 33'(-e_w) : 33'(e_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ta_ff <= '0;
      end else begin
         ta_ff <= t1_o;
      end
   end

   // stage b: 33x33 product
   logic [65:0] prod_ff;
   t1_type tb_ff;
   logic signed [31:0] mnb_ff;
   always_ff @(posedge clock) begin
      prod_ff <= ad_ff * ae_ff;
      mnb_ff <= mnew_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tb_ff <= '0;
      end else begin
         tb_ff <= ta_ff;
      end
   end

   // m2 update with saturation
   logic [49:0] inc;
   logic [M2_W:0] sum;
   logic [M2_W-1:0] m2n;
   assign inc = prod_ff[65:16];
   assign sum = {1'b0, tb_ff.m2} + {1'b0, inc[M2_W-1:0]};
   assign m2n = (inc[49:48] != 2'b00 || sum[M2_W]) ? M2_MAX : sum[M2_W-1:0];

   // store write, or clearing pass
   always_ff @(posedge clock) begin
      if (clr_act_ff) begin
         mean_mem[clr_ff] <= '0;
         m2_mem[clr_ff] <= '0;
      end else if (tb_ff.v && tb_ff.j.in_field) begin
         mean_mem[tb_ff.j.idx] <= mnb_ff;
         m2_mem[tb_ff.j.idx] <= m2n;
      end
   end

   typedef struct packed {
      logic signed [31:0] mean;
      logic inf;
      logic first;
      logic v;
   } t2_type;
   t2_type t2_i, t2_o;
   logic [M2_W-1:0] vq;
   logic [FRM_W:0] nm1;
   assign nm1 = (tb_ff.j.n > 1) ? tb_ff.j.n - 1'b1 : (FRM_W+1)'(1);
   assign t2_i = '{mean: mnb_ff, inf: tb_ff.j.in_field, first: (tb_ff.j.n < 2), v: tb_ff.v};

   rmvf_div #(.NW(M2_W), .DW(FRM_W+1), .TW($bits(t2_type))) u_div2 (
      .clock(clock), .reset(reset), .en(en), .num(m2n), .den(nm1),
      .tag_i(t2_i), .quo(vq), .tag_o(t2_o));

   // output fifo with registered read into the output register
   rsp_type f_mem [FIFO_D];
   logic [FA-1:0] wp_ff, rp_ff;
   rsp_type out_ff;
   rsp_type r_w;
   logic push, pop, load, from_mem, direct, mem_wr;
   assign push = t2_o.v;
   assign r_w.mean_out = t2_o.inf ? t2_o.mean : 32'sd0;
   assign r_w.variance_out = (t2_o.inf && !t2_o.first) ? vq : '0;
   assign r_w.variance_valid = t2_o.inf && !t2_o.first;
   assign out_valid = ov_ff;
   assign out_data = out_ff;
   assign pop = ov_ff && out_ready;
   assign load = !ov_ff || pop;
   assign from_mem = load && (mcnt_ff != 0);
   assign direct = load && (mcnt_ff == 0) && push;
   assign mem_wr = push && !direct;

   always_ff @(posedge clock) begin
      if (mem_wr) f_mem[wp_ff] <= r_w;
   end

   always_ff @(posedge clock) begin
      if (from_mem) begin
         out_ff <= f_mem[rp_ff];
      end else if (direct) begin
         out_ff <= r_w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         mcnt_ff <= '0;
         ov_ff <= 1'b0;
         fly_ff <= '0;
      end else begin
         if (mem_wr) wp_ff <= wp_ff + 1'b1;
         if (from_mem) rp_ff <= rp_ff + 1'b1;
         mcnt_ff <= mcnt_ff + (FA+1)'(mem_wr) - (FA+1)'(from_mem);
         if (load) ov_ff <= from_mem || direct;
         fly_ff <= fly_ff + 8'(fire) - 8'(push);
      end
   end

   `RMVF_ASSERT_IMPL(a_fifo_bound, clock, reset, 1'b1, 32'(mcnt_ff) + 32'(ov_ff) <= FIFO_D)
   `RMVF_ASSERT_IMPL(a_fly_bound, clock, reset, 1'b1, 32'(fly_ff) <= LAT)
   `RMVF_ASSERT_IMPL(a_first_var, clock, reset, push && t2_o.first, !r_w.variance_valid)
   `RMVF_ASSERT_IMPL(a_no_fire_clear, clock, reset, clr_act_ff, !fire)
endmodule

@@ sim/running_mean_variance_field_test.sv @@
module running_mean_variance_field_test;
   import rmvf_pkg::*;

   localparam int unsigned ROWS = 32;
   localparam int unsigned COLS = 32;
   localparam int unsigned CELLS = ROWS * COLS;
   localparam int unsigned SLOTS = 256;
   localparam int unsigned PHASE_ITEMS = 300;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned DRAIN_CYCLES = 200;
   localparam int unsigned HOLD_CYCLES = 600;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;

   // predictor state
   logic signed [31:0] mean_mem [DEPTH];
   logic [M2_W-1:0] m2_mem [DEPTH];
   logic [FRM_W-1:0] frame_count;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   logic hold_go = 1'b0;
   logic hold_seen = 1'b0;
   int unsigned hold_cycles = 0;
   int unsigned cycle_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned slot = 0;

   running_mean_variance_field #(.ROWS(ROWS), .COLS(COLS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // welford update of one element, returns the expected result
   function automatic rsp_type welford_update(req_type item);
      rsp_type r;
      longint x, mean, d, mean_new, e, n;
      logic [63:0] ad, ae, inc, m2;
      n = longint'(frame_count) + 1;
      if (32'(item.element_index) >= CELLS) begin
         r = '0;
      end else begin
         x = longint'(item.sample);
         mean = longint'(mean_mem[item.element_index]);
         d = x - mean;
         mean_new = mean + d / n;
         e = x - mean_new;
         ad = (d < 0) ? -d : d;
         ae = (e < 0) ? -e : e;
         inc = (ad * ae) >> 16;
         m2 = {16'd0, m2_mem[item.element_index]};
         if (inc > {16'd0, M2_MAX} - m2) m2 = {16'd0, M2_MAX};
         else m2 = m2 + inc;
         mean_mem[item.element_index] = mean_new[31:0];
         m2_mem[item.element_index] = m2[M2_W-1:0];
         r.mean_out = mean_new[31:0];
         if (n >= 2) begin
            r.variance_out = 48'(m2 / 64'(n - 1));
            r.variance_valid = 1'b1;
         end else begin
            r.variance_out = '0;
            r.variance_valid = 1'b0;
         end
      end
      if (item.last_in_frame && frame_count != FRAMES_MAX) frame_count = frame_count + 1'b1;
      return r;
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      mismatch_count++;
   endtask

   // next item over a rotating set of slots so an element is revisited only a pass later
   task automatic queue_item(logic signed [31:0] value);
      req_type item;
      logic [7:0] s;
      s = slot[7:0];
      item.sample = value;
      item.element_index = {s, s[1:0] ^ s[7:6]};
      item.last_in_frame = (s == 8'(SLOTS - 1)) || ($urandom_range(99) < 2);
      pending_reqs.push_back(item);
      slot = (slot + 1) % SLOTS;
   endtask

   function automatic logic signed [31:0] random_sample();
      case ($urandom_range(7))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return 32'(int'($urandom_range(2000)) - 1000);
         default: return $urandom;
      endcase
   endfunction

   // driver: offers items and predicts on each transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) expected_rsps.push_back(welford_update(req_data));
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: random back pressure and field compare
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report("unexpected transfer", 64'(rsp_data.mean_out), '0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.mean_out !== want.mean_out)
                  report("mean_out", 64'(rsp_data.mean_out), 64'(want.mean_out));
               if (rsp_data.variance_out !== want.variance_out)
                  report("variance_out", 64'(rsp_data.variance_out),
                         64'(want.variance_out));
               if (rsp_data.variance_valid !== want.variance_valid)
                  report("variance_valid", 64'(rsp_data.variance_valid),
                         64'(want.variance_valid));
            end
         end
      end
      rsp_ready <= !reset && hold_cycles == 0 && $urandom_range(99) >= recv_stall_pct;
   end

   // long hold-off counted here
   always @(posedge clock) begin
      if (hold_go && !hold_seen) begin
         hold_cycles <= HOLD_CYCLES;
         hold_seen <= 1'b1;
      end else if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      logic signed [31:0] extremes [6];
      extremes = '{32'sh7fffffff, 32'sh80000000, 32'sh0, 32'sh1, -32'sh1, 32'sh00010000};
      for (int i = 0; i < DEPTH; i++) begin
         mean_mem[i] = '0;
         m2_mem[i] = '0;
      end
      frame_count = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 66; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 66; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase
         // directed extremes at the start
         if (phase == 0) begin
            for (int i = 0; i < 24; i++) queue_item(extremes[i % 6]);
         end
         for (int i = 0; i < PHASE_ITEMS; i++) queue_item(random_sample());
         // hold off the receiver once results flow, so the block fills up
         if (phase == 0) begin
            while (!rsp_valid) @(posedge clock);
            hold_go <= 1'b1;
         end
         while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
            @(posedge clock);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
